/* hw/rtl/lfsc_pkg.sv */
// Shared types, codes and reset values for the line-follow steering control block.
package lfsc_pkg;

  // Fixed field widths
  localparam int SensorCount = 5;
  localparam int TickW       = 5;
  localparam int PopW        = 3;
  localparam int CountW      = 6;
  localparam int ApbAddrW    = 5;
  localparam int ApbDataW    = 32;

  localparam int PeriodTicksDefault = 32;

  localparam logic [CountW-1:0] CountMax = 6'd63;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] RegInvertThr     = 3'd0;
  localparam logic [2:0] RegStraightOn    = 3'd1;
  localparam logic [2:0] RegSlowStraightOn = 3'd2;
  localparam logic [2:0] RegTurnOn        = 3'd3;
  localparam logic [2:0] RegSmallTurnOn   = 3'd4;
  localparam logic [2:0] RegBigTurnOn     = 3'd5;

  // Configuration reset values
  localparam logic [2:0] InvertThrReset       = 3'd4;
  localparam logic [4:0] StraightOnReset      = 5'd18;
  localparam logic [4:0] SlowStraightOnReset  = 5'd12;
  localparam logic [4:0] TurnOnReset          = 5'd10;
  localparam logic [4:0] SmallTurnOnReset     = 5'd8;
  localparam logic [4:0] BigTurnOnReset       = 5'd15;

  // Sensor patterns, bit4 leftmost
  localparam logic [4:0] PatCenter     = 5'b00100;
  localparam logic [4:0] PatCenterInv  = 5'b11011;
  localparam logic [4:0] PatWide       = 5'b01110;
  localparam logic [4:0] PatEdges      = 5'b10001;
  localparam logic [4:0] PatRight1     = 5'b00001;
  localparam logic [4:0] PatRight2     = 5'b00011;
  localparam logic [4:0] PatRight3     = 5'b00111;
  localparam logic [4:0] PatSmallRight1 = 5'b00010;
  localparam logic [4:0] PatSmallRight2 = 5'b00110;
  localparam logic [4:0] PatLeft1      = 5'b10000;
  localparam logic [4:0] PatLeft2      = 5'b11000;
  localparam logic [4:0] PatLeft3      = 5'b11100;
  localparam logic [4:0] PatSmallLeft1 = 5'b01000;
  localparam logic [4:0] PatSmallLeft2 = 5'b01100;
  localparam logic [4:0] PatNone       = 5'b00000;
  localparam logic [4:0] PatAll        = 5'b11111;

  // Remembered side of the line
  localparam logic [1:0] SideNone  = 2'd0;
  localparam logic [1:0] SideLeft  = 2'd1;
  localparam logic [1:0] SideRight = 2'd2;

  // Motor enable codes
  localparam logic [1:0] MotorOff   = 2'b00;
  localparam logic [1:0] MotorRight = 2'b01;
  localparam logic [1:0] MotorLeft  = 2'b10;
  localparam logic [1:0] MotorBoth  = 2'b11;

  typedef enum logic [2:0] {
    MoveStraight     = 3'd0,
    MoveSlowStraight = 3'd1,
    MoveRight        = 3'd2,
    MoveSmallRight   = 3'd3,
    MoveBigRight     = 3'd4,
    MoveLeft         = 3'd5,
    MoveSmallLeft    = 3'd6,
    MoveBigLeft      = 3'd7
  } move_e;

  typedef struct packed {
    logic [4:0] sensor_bits;
    logic [4:0] tick;
  } lfsc_in_t;

  typedef struct packed {
    logic [2:0] move_code;
    logic [1:0] motor_enables;
    logic       inverted_mode;
  } lfsc_out_t;

endpackage

/* hw/rtl/line_follow_steering_control.sv */
// Top level of the line-follow steering control block.
//
// Usage: one sensor sample and its tick index enter on the input valid/ready
// channel; one steering result (move code, motor enables, inverted flag)
// leaves on the output valid/ready channel for every transfer taken in.
// Thresholds sit in six APB registers at byte addresses 0, 4, ... 20; the user
// must write them only while the block is idle; the block itself does not enforce this.
// Each result passes the read stage, then the output register. Throughput: one
// sample per cycle while output ready holds. The popcount log is a synchronous
// memory read at input transfer and written back as the sample leaves stage 1;
// a same-slot write in flight is forwarded, so back-to-back samples on one tick
// stay exact. The running inverted count and the last side update alongside it.
// Reset: registers take their default thresholds, the count and last side
// clear, and per-entry valid bits in flip-flops clear at once, so the log
// reads as all zero with no clearing pass; the block is ready right away.
// Stall: a result waits in the output register; one more sample can enter
// the read stage, after which input ready follows output ready.
module line_follow_steering_control #(
  parameter int PERIOD_TICKS = lfsc_pkg::PeriodTicksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfsc_pkg::ApbAddrW-1:0] paddr,
  input  logic [lfsc_pkg::ApbDataW-1:0] pwdata,
  output logic [lfsc_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lfsc_pkg::lfsc_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lfsc_pkg::lfsc_out_t          out_data_o
);
  import lfsc_pkg::*;

  localparam int SlotW    = $clog2(PERIOD_TICKS);
  localparam int TickSpan = 1 << TickW;
  localparam logic [8:0] HalfTicks = 9'(PERIOD_TICKS / 2);

  // Configuration registers
  logic [2:0] inv_thr_q;
  logic [4:0] straight_on_q, slow_on_q, turn_on_q, small_on_q, big_on_q;
  logic       cfg_wr;

  // Pipeline and state
  logic                  in_fire, s1_adv;
  logic                  s1_valid_q;
  logic [4:0]            s1_line_q, s1_tick_q;
  logic [SlotW-1:0]      s1_slot_q, slot_in;
  logic [SlotW-1:0]      slot_lut [TickSpan];
  logic [PopW-1:0]       log_mem [PERIOD_TICKS];
  logic [PERIOD_TICKS-1:0] log_vld_q;
  logic [PopW-1:0]       rd_pop_q, fwd_pop_q, old_pop, new_pop;
  logic                  rd_vld_q, fwd_hit_q;
  logic [CountW-1:0]     cnt_q, cnt_mid, cnt_d;
  logic [1:0]            side_q, side_d;
  logic                  inv;
  logic [4:0]            line_eff;
  move_e                 move;
  logic [1:0]            motor;
  logic                  out_valid_q;
  lfsc_out_t             out_data_q;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_thr_q     <= InvertThrReset;
      straight_on_q <= StraightOnReset;
      slow_on_q     <= SlowStraightOnReset;
      turn_on_q     <= TurnOnReset;
      small_on_q    <= SmallTurnOnReset;
      big_on_q      <= BigTurnOnReset;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegInvertThr:      inv_thr_q     <= pwdata[2:0];
        RegStraightOn:     straight_on_q <= pwdata[4:0];
        RegSlowStraightOn: slow_on_q     <= pwdata[4:0];
        RegTurnOn:         turn_on_q     <= pwdata[4:0];
        RegSmallTurnOn:    small_on_q    <= pwdata[4:0];
        RegBigTurnOn:      big_on_q      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegInvertThr:      prdata = ApbDataW'(inv_thr_q);
      RegStraightOn:     prdata = ApbDataW'(straight_on_q);
      RegSlowStraightOn: prdata = ApbDataW'(slow_on_q);
      RegTurnOn:         prdata = ApbDataW'(turn_on_q);
      RegSmallTurnOn:    prdata = ApbDataW'(small_on_q);
      RegBigTurnOn:      prdata = ApbDataW'(big_on_q);
      default:           prdata = '0;
    endcase
  end

  // Map tick to log slot (tick modulo period), worked out at elaboration
  for (genvar g = 0; g < TickSpan; g++) begin : g_slot
    localparam int SlotVal = g % PERIOD_TICKS;
    assign slot_lut[g] = SlotW'(SlotVal);
  end
  assign slot_in = slot_lut[in_data_i.tick];

  // Handshake: stage 1 advances when the output register is free or is being emptied
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the sample and the registered log read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_line_q <= in_data_i.sensor_bits;
      s1_tick_q <= in_data_i.tick;
      s1_slot_q <= slot_in;
      rd_vld_q  <= log_vld_q[slot_in];
      fwd_hit_q <= s1_adv && (s1_slot_q == slot_in);
      fwd_pop_q <= new_pop;
    end
  end

  // Popcount log memory: write back at stage 1, read at input transfer
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      log_mem[s1_slot_q] <= new_pop;
    end
    if (in_fire) begin
      rd_pop_q <= log_mem[slot_in];
    end
  end

  // Entry valid bits stand in for the cleared log after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_vld_q <= '0;
    end else if (s1_adv) begin
      log_vld_q[s1_slot_q] <= 1'b1;
    end
  end

  // Popcount of the new sample
  always_comb begin
    new_pop = '0;
    for (int i = 0; i < SensorCount; i++) begin
      new_pop = new_pop + PopW'(s1_line_q[i]);
    end
  end

  // Old entry, forwarded when the previous item wrote the same slot as this one was read
  assign old_pop = fwd_hit_q ? fwd_pop_q : (rd_vld_q ? rd_pop_q : '0);

  // Drop the replaced entry, add the new one, saturating both ways
  always_comb begin
    cnt_mid = ((old_pop >= inv_thr_q) && (cnt_q != '0)) ? cnt_q - 1'b1 : cnt_q;
    cnt_d   = ((new_pop >= inv_thr_q) && (cnt_mid != CountMax)) ? cnt_mid + 1'b1 : cnt_mid;
  end

  assign inv      = {3'b000, cnt_d} > HalfTicks;
  assign line_eff = inv ? ~s1_line_q : s1_line_q;

  // Classify the pattern into a move and track the side of the line
  always_comb begin
    move   = MoveStraight;
    side_d = side_q;
    case (line_eff)
      PatCenter, PatCenterInv: begin
        move   = MoveStraight;
        side_d = SideNone;
      end
      PatWide, PatEdges: begin
        move   = MoveSlowStraight;
        side_d = SideNone;
      end
      PatRight1, PatRight2, PatRight3: begin
        move   = MoveRight;
        side_d = SideRight;
      end
      PatSmallRight1, PatSmallRight2: begin
        move   = MoveSmallRight;
        side_d = SideRight;
      end
      PatLeft1, PatLeft2, PatLeft3: begin
        move   = MoveLeft;
        side_d = SideLeft;
      end
      PatSmallLeft1, PatSmallLeft2: begin
        move   = MoveSmallLeft;
        side_d = SideLeft;
      end
      PatNone, PatAll: begin
        if (side_q == SideLeft) begin
          move = MoveBigLeft;
        end else if (side_q == SideRight) begin
          move = MoveBigRight;
        end else begin
          move = MoveStraight;
        end
      end
      default: ;
    endcase
  end

  // Motor enables, gated off past each move's last tick
  always_comb begin
    case (move)
      MoveStraight:     motor = (s1_tick_q <= straight_on_q) ? MotorBoth : MotorOff;
      MoveSlowStraight: motor = (s1_tick_q <= slow_on_q) ? MotorBoth : MotorOff;
      MoveRight:        motor = (s1_tick_q <= turn_on_q) ? MotorRight : MotorOff;
      MoveSmallRight:   motor = (s1_tick_q <= small_on_q) ? MotorRight : MotorOff;
      MoveBigRight:     motor = (s1_tick_q <= big_on_q) ? MotorRight : MotorOff;
      MoveLeft:         motor = (s1_tick_q <= turn_on_q) ? MotorLeft : MotorOff;
      MoveSmallLeft:    motor = (s1_tick_q <= small_on_q) ? MotorLeft : MotorOff;
      default:          motor = (s1_tick_q <= big_on_q) ? MotorLeft : MotorOff;
    endcase
  end

  // Advance count and side with each completed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      side_q <= SideNone;
    end else if (s1_adv) begin
      cnt_q  <= cnt_d;
      side_q <= side_d;
    end
  end

  // Output register: hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q.move_code     <= move;
      out_data_q.motor_enables <= motor;
      out_data_q.inverted_mode <= inv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hw/rtl/lfsc_checker.sv */
// Port-level checker for the line-follow steering control block, with its bind.
module lfsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input lfsc_pkg::lfsc_out_t           out_data_o
);
  import lfsc_pkg::*;

  // Stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // After one transfer into a stalled block, input ready follows output ready
  a_skid_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=> in_ready_o == out_ready_i)
    else $error("more than one item taken behind a stalled result");

  // Right-side turns never drive the left motor
  a_right_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.move_code == MoveRight ||
                    out_data_o.move_code == MoveSmallRight ||
                    out_data_o.move_code == MoveBigRight) |-> !out_data_o.motor_enables[1])
    else $error("left motor on for a right turn");

  // Left-side turns never drive the right motor
  a_left_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.move_code == MoveLeft ||
                    out_data_o.move_code == MoveSmallLeft ||
                    out_data_o.move_code == MoveBigLeft) |-> !out_data_o.motor_enables[0])
    else $error("right motor on for a left turn");

  // No result shows while reset is held past its first edge
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni && $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind line_follow_steering_control lfsc_checker u_lfsc_checker (.*);
